// ----- hdl/swtm_pkg.sv -----
// Shared constants for the sliding window trimmed mean unit.
package swtm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MEAN_W         = 16;
    localparam int LEN_W          = 11;
    localparam int TRIM_W         = 9;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 11;
    localparam int VALUE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT    = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(3);
    localparam logic [TRIM_W-1:0] TRIM_RESET = TRIM_W'(1);

endpackage

// ----- hdl/swtm_if.sv -----
// Valid/ready channel interfaces for samples and results.
interface swtm_in_if import swtm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface swtm_out_if import swtm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] trimmed_mean;
    logic              mean_ready;

    modport source (output valid, output trimmed_mean, output mean_ready, input ready);
    modport sink   (input valid, input trimmed_mean, input mean_ready, output ready);
endinterface

// ----- hdl/swtm_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module swtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/swtm_div.sv -----
// Restoring divider, one quotient bit per cycle.
module swtm_div #(
    parameter int NW = 27,
    parameter int DW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    q_reg, q_next;
    logic [DW:0]      r_reg, r_next;
    logic [DW-1:0]    d_reg, d_next;
    logic [DW:0]      r_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        r_sh      = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hdl/sliding_window_trimmed_mean_unit.sv -----
// Sliding window trimmed mean over a FIFO RAM and a combined count/sum Fenwick tree RAM.
// Each sample runs one tree update pass while filling, two when full; then, if the window is
// full and the configuration valid, two tree descents and a division. One sample in flight.
// Reset and every window_length write run a pass that clears every tree entry, during
// which no sample is accepted.
module sliding_window_trimmed_mean_unit import swtm_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    swtm_in_if.sink               sample_ch,
    swtm_out_if.source            result_ch
);

    localparam int VB = VALUE_BITS;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int SW = VB + CW;
    localparam int TW = CW + SW;
    localparam int QW = (SW > MEAN_W) ? SW : MEAN_W;
    localparam int BW = $clog2(VB);
    localparam int TN = 1 << VB;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FIFO_RD, S_UPD_RD, S_UPD_WR, S_DSC_RD, S_DSC_CMP,
        S_MUL, S_ACC, S_DIV_WAIT, S_DONE
    } state_t;

    state_t          state_reg;
    logic [LEN_W-1:0]  wlen_reg;
    logic [TRIM_W-1:0] trim_reg;
    logic [AW-1:0]   head_reg, hd_reg;
    logic [CW-1:0]   fill_reg, len_reg, rem_reg;
    logic [SW-1:0]   wsum_reg, acc_reg, low_reg, prod_reg;
    logic [VB-1:0]   s_reg, old_reg, pos_reg, clr_reg;
    logic [VB:0]     p_reg;
    logic [BW-1:0]   b_reg;
    logic            sub_reg, phase_reg, pass_reg, done_ok_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic            out_valid_reg;
    logic [MEAN_W-1:0] out_mean_reg;
    logic            out_ready_reg;

    logic [CW-1:0]   len_c, k_c, dsor_c;
    logic [AW-1:0]   head_c;
    logic            cfg_ok;
    logic            wlen_wr_c, out_load_c;
    logic [VB-1:0]   s_in, bit_c;
    logic [VB+1:0]   p_ext, pn;
    logic [CW-1:0]   rcnt;
    logic [SW-1:0]   rsum, dsum, acc_sum;
    logic [CW-1:0]   dcnt;

    logic            fifo_we;
    logic [AW-1:0]   fifo_waddr, fifo_raddr;
    logic [VB-1:0]   fifo_wdata, fifo_rdata;
    logic            tree_we;
    logic [VB-1:0]   tree_waddr, tree_raddr;
    logic [TW-1:0]   tree_wdata, tree_rdata;
    logic            div_start, div_done;
    logic [QW-1:0]   div_q;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_c = CW'(1);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            len_c = CW'(MAX_WINDOW);
        end
        else
        begin
            len_c = CW'(wlen_reg);
        end
    end

    assign cfg_ok  = (wlen_reg != '0) && (32'(wlen_reg) <= MAX_WINDOW)
                     && ({trim_reg, 1'b0} < {1'b0, wlen_reg});
    assign wlen_wr_c  = cfg_we && (cfg_index == REG_WINDOW_LENGTH);
    assign out_load_c = (state_reg == S_DONE) && (!out_valid_reg || result_ch.ready)
                        && !wlen_wr_c;
    assign k_c     = CW'(trim_reg);
    assign dsor_c  = len_reg - (k_c << 1);
    assign head_c  = (CW'(head_reg) < len_c) ? head_reg : '0;
    assign s_in    = VB'(sample_ch.sample_value);
    assign bit_c   = VB'(1) << b_reg;
    assign p_ext   = {1'b0, p_reg};
    assign pn      = p_ext + (p_ext & (-p_ext));
    assign rcnt    = tree_rdata[TW-1:SW];
    assign rsum    = tree_rdata[SW-1:0];
    assign dcnt    = phase_reg ? {CW{1'b1}} : CW'(1);
    assign dsum    = phase_reg ? (SW'(0) - SW'(old_reg)) : SW'(s_reg);
    assign acc_sum = acc_reg + prod_reg;

    // memory port steering
    always_comb
    begin
        fifo_we    = 1'b0;
        fifo_waddr = hd_reg;
        fifo_wdata = s_reg;
        fifo_raddr = head_c;
        tree_we    = 1'b0;
        tree_waddr = p_reg[VB-1:0] - VB'(1);
        tree_wdata = {rcnt + dcnt, rsum + dsum};
        tree_raddr = p_reg[VB-1:0] - VB'(1);
        unique case (state_reg)
            S_CLEAR:
            begin
                tree_we    = 1'b1;
                tree_waddr = clr_reg;
                tree_wdata = '0;
            end
            S_IDLE:
            begin
                if (sample_ch.valid && (fill_reg < len_c))
                begin
                    fifo_we    = 1'b1;
                    fifo_waddr = AW'(fill_reg);
                    fifo_wdata = s_in;
                end
            end
            S_FIFO_RD:
            begin
                fifo_we = 1'b1;
            end
            S_UPD_WR:
            begin
                tree_we = 1'b1;
            end
            S_DSC_RD:
            begin
                tree_raddr = (pos_reg | bit_c) - VB'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign div_start = (state_reg == S_ACC) && pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            wlen_reg      <= LEN_RESET;
            trim_reg      <= TRIM_RESET;
            head_reg      <= '0;
            fill_reg      <= '0;
            wsum_reg      <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wlen_wr_c)
            begin
                wlen_reg  <= cfg_data[LEN_W-1:0];
                head_reg  <= '0;
                fill_reg  <= '0;
                wsum_reg  <= '0;
                clr_reg   <= '0;
                state_reg <= S_CLEAR;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + VB'(1);
                        if (clr_reg == {VB{1'b1}})
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (sample_ch.valid)
                        begin
                            s_reg     <= s_in;
                            len_reg   <= len_c;
                            phase_reg <= 1'b0;
                            if (fill_reg < len_c)
                            begin
                                fill_reg  <= fill_reg + CW'(1);
                                wsum_reg  <= wsum_reg + SW'(s_in);
                                p_reg     <= {1'b0, s_in} + (VB+1)'(1);
                                sub_reg   <= 1'b0;
                                state_reg <= S_UPD_RD;
                            end
                            else
                            begin
                                hd_reg    <= head_c;
                                sub_reg   <= 1'b1;
                                state_reg <= S_FIFO_RD;
                            end
                        end
                    end
                    S_FIFO_RD:
                    begin
                        old_reg   <= fifo_rdata;
                        head_reg  <= (CW'(hd_reg) + CW'(1) >= len_reg) ? '0 : hd_reg + AW'(1);
                        wsum_reg  <= wsum_reg + SW'(s_reg) - SW'(fifo_rdata);
                        p_reg     <= {1'b0, s_reg} + (VB+1)'(1);
                        state_reg <= S_UPD_RD;
                    end
                    S_UPD_RD:
                    begin
                        state_reg <= S_UPD_WR;
                    end
                    S_UPD_WR:
                    begin
                        if (pn <= (VB+2)'(TN))
                        begin
                            p_reg     <= pn[VB:0];
                            state_reg <= S_UPD_RD;
                        end
                        else if (sub_reg && !phase_reg)
                        begin
                            phase_reg <= 1'b1;
                            p_reg     <= {1'b0, old_reg} + (VB+1)'(1);
                            state_reg <= S_UPD_RD;
                        end
                        else if (cfg_ok && (fill_reg >= len_reg))
                        begin
                            pass_reg  <= 1'b0;
                            pos_reg   <= '0;
                            b_reg     <= BW'(VB - 1);
                            rem_reg   <= k_c;
                            acc_reg   <= '0;
                            state_reg <= S_DSC_RD;
                        end
                        else
                        begin
                            done_ok_reg <= 1'b0;
                            mean_reg    <= '0;
                            state_reg   <= S_DONE;
                        end
                    end
                    S_DSC_RD:
                    begin
                        state_reg <= S_DSC_CMP;
                    end
                    S_DSC_CMP:
                    begin
                        if (rcnt < rem_reg)
                        begin
                            pos_reg <= pos_reg | bit_c;
                            rem_reg <= rem_reg - rcnt;
                            acc_reg <= acc_reg + rsum;
                        end
                        if (b_reg == '0)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            b_reg     <= b_reg - BW'(1);
                            state_reg <= S_DSC_RD;
                        end
                    end
                    S_MUL:
                    begin
                        prod_reg  <= SW'(rem_reg) * SW'(pos_reg);
                        state_reg <= S_ACC;
                    end
                    S_ACC:
                    begin
                        if (!pass_reg)
                        begin
                            low_reg   <= acc_sum;
                            pass_reg  <= 1'b1;
                            pos_reg   <= '0;
                            b_reg     <= BW'(VB - 1);
                            rem_reg   <= len_reg - k_c;
                            acc_reg   <= '0;
                            state_reg <= S_DSC_RD;
                        end
                        else
                        begin
                            state_reg <= S_DIV_WAIT;
                        end
                    end
                    S_DIV_WAIT:
                    begin
                        if (div_done)
                        begin
                            done_ok_reg <= 1'b1;
                            mean_reg    <= div_q[MEAN_W-1:0];
                            state_reg   <= S_DONE;
                        end
                    end
                    S_DONE:
                    begin
                        if (out_load_c)
                        begin
                            out_mean_reg  <= mean_reg;
                            out_ready_reg <= done_ok_reg;
                            state_reg     <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
            if (cfg_we && (cfg_index == REG_TRIM_COUNT))
            begin
                trim_reg <= cfg_data[TRIM_W-1:0];
            end
        end
    end

    swtm_ram #(
        .WIDTH (VB),
        .DEPTH (MAX_WINDOW)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    swtm_ram #(
        .WIDTH (TW),
        .DEPTH (TN)
    ) u_tree_ram (
        .clk   (clk),
        .we    (tree_we),
        .waddr (tree_waddr),
        .wdata (tree_wdata),
        .raddr (tree_raddr),
        .rdata (tree_rdata)
    );

    swtm_div #(
        .NW (QW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (QW'(acc_sum - low_reg)),
        .divisor  (dsor_c),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sample_ch.ready        = (state_reg == S_IDLE);
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.trimmed_mean = out_mean_reg;
    assign result_ch.mean_ready   = out_ready_reg;

endmodule

// ----- hdl/swtm_checker.sv -----
// Port-level assertions for the trimmed mean unit, bound to the top level.
module swtm_checker import swtm_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [MEAN_W-1:0] trimmed_mean,
    input logic              mean_ready
);

    // one transaction in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample accepted while previous one still in flight");

    a_zero_when_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mean_ready |-> trimmed_mean == '0)
        else $error("nonzero mean without mean_ready");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(trimmed_mean)
                                    && $stable(mean_ready))
        else $error("stalled result changed");

endmodule

bind sliding_window_trimmed_mean_unit swtm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .trimmed_mean (result_ch.trimmed_mean),
    .mean_ready   (result_ch.mean_ready)
);
